// ===== src/ssr_pkg.sv =====
package ssr_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_SUBST_DEF   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_LEN = 3'd5;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] sub_lo;
    logic [CFG_DATA_W-1:0] sub_hi;
    logic [LEN_W-1:0]      sub_len;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic marker;
  } load_t;

  // Byte k of a 16-byte value split over two words; positions 16 and up read 0.
  function automatic logic [BYTE_W-1:0] cfg_byte(input logic [CFG_DATA_W-1:0] lo,
                                                 input logic [CFG_DATA_W-1:0] hi,
                                                 input int k);
    logic [CFG_DATA_W-1:0] sh;
    sh = '0;
    if (k < 8) begin
      sh = lo >> (8 * k);
    end else if (k < 16) begin
      sh = hi >> (8 * (k - 8));
    end
    return sh[BYTE_W-1:0];
  endfunction

endpackage

// ===== src/ssr_cfg.sv =====
module ssr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output ssr_pkg::cfg_t                       cfg_o
);

  ssr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssr_pkg::REG_PAT_LO:  cfg_q.pat_lo  <= cfg_data_i;
        ssr_pkg::REG_PAT_HI:  cfg_q.pat_hi  <= cfg_data_i;
        ssr_pkg::REG_PAT_LEN: cfg_q.pat_len <= cfg_data_i[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_SUB_LO:  cfg_q.sub_lo  <= cfg_data_i;
        ssr_pkg::REG_SUB_HI:  cfg_q.sub_hi  <= cfg_data_i;
        ssr_pkg::REG_SUB_LEN: cfg_q.sub_len <= cfg_data_i[ssr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ssr_core.sv =====
module ssr_core #(
  parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_SUBST   = ssr_pkg::MAX_SUBST_DEF,
  parameter int BURST       = (MAX_PATTERN > MAX_SUBST) ? MAX_PATTERN : MAX_SUBST,
  localparam int BurstW     = $clog2(BURST + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ssr_pkg::BYTE_W-1:0]           in_byte_i,
  input  logic                                 in_eot_i,
  input  ssr_pkg::cfg_t                        cfg_i,
  input  logic                                 load_ok_i,
  output ssr_pkg::load_t                       load_o,
  output logic [BURST-1:0][ssr_pkg::BYTE_W-1:0] bytes_o,
  output logic [BurstW-1:0]                    count_o
);

  localparam int CntW = $clog2(MAX_PATTERN + 1);
  localparam int SubW = $clog2(MAX_SUBST + 1);
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic                                       in_vld_q;
  logic [ssr_pkg::BYTE_W-1:0]                 in_byte_q;
  logic                                       in_eot_q;
  logic [CntW-1:0]                            cnt_q, cnt_d;
  logic [MAX_PATTERN-1:0][ssr_pkg::BYTE_W-1:0] win_q, win_d;
  logic [MAX_PATTERN-1:0][ssr_pkg::BYTE_W-1:0] wp;

  logic [CntW-1:0]   plen, w, keep, win_n;
  logic [SubW-1:0]   slen;
  logic              match, use_sub, marker, need_out, advance;
  logic [BurstW-1:0] total;

  always_comb begin
    if (int'(cfg_i.pat_len) > MAX_PATTERN) begin
      plen = CntW'(MAX_PATTERN);
    end else begin
      plen = CntW'(cfg_i.pat_len);
    end
    if (int'(cfg_i.sub_len) > MAX_SUBST) begin
      slen = SubW'(MAX_SUBST);
    end else begin
      slen = SubW'(cfg_i.sub_len);
    end
  end

  // Window as it stands with the new byte appended.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (CntW'(k) < cnt_q) begin
        wp[k] = win_q[k];
      end else if (CntW'(k) == cnt_q) begin
        wp[k] = in_byte_q;
      end else begin
        wp[k] = '0;
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (CntW'(k) < plen &&
          wp[k] != ssr_pkg::cfg_byte(cfg_i.pat_lo, cfg_i.pat_hi, k)) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    w       = cnt_q + CntW'(1);
    use_sub = 1'b0;
    if (plen == '0) begin
      keep = '0;
    end else if (w > plen) begin
      keep = plen - CntW'(1);
    end else if (w == plen) begin
      use_sub = match;
      keep    = match ? '0 : plen - CntW'(1);
    end else begin
      keep = w;
    end
    if (in_eot_q) begin
      keep = '0;
    end
    win_n    = use_sub ? '0 : w - keep;
    total    = use_sub ? BurstW'(slen) : BurstW'(win_n);
    marker   = in_eot_q && (total == '0);
    need_out = (total != '0) || in_eot_q;
    advance  = in_vld_q && (!need_out || load_ok_i);
  end

  // Drop the emitted bytes from the front of the window.
  always_comb begin
    logic [CntW:0] idx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = (CntW + 1)'(k) + (CntW + 1)'(win_n);
      if (idx < (CntW + 1)'(MAX_PATTERN)) begin
        win_d[k] = wp[idx[IdxW-1:0]];
      end else begin
        win_d[k] = '0;
      end
    end
    cnt_d = advance ? keep : cnt_q;
  end

  always_comb begin
    for (int j = 0; j < BURST; j++) begin
      bytes_o[j] = '0;
      if (!marker) begin
        if (use_sub) begin
          if (j < MAX_SUBST) begin
            bytes_o[j] = ssr_pkg::cfg_byte(cfg_i.sub_lo, cfg_i.sub_hi, j);
          end
        end else if (j < MAX_PATTERN) begin
          bytes_o[j] = wp[j];
        end
      end
    end
  end

  assign load_o.load   = advance && need_out;
  assign load_o.marker = marker;
  assign count_o       = marker ? BurstW'(1) : total;
  assign in_ready_o    = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_eot_q  <= in_eot_i;
    end
    if (advance) begin
      win_q <= win_d;
    end
  end

endmodule

// ===== src/ssr_burst.sv =====
module ssr_burst #(
  parameter int DEPTH   = ssr_pkg::MAX_PATTERN_DEF,
  localparam int BurstW = $clog2(DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ssr_pkg::load_t                       load_i,
  input  logic [DEPTH-1:0][ssr_pkg::BYTE_W-1:0] bytes_i,
  input  logic [BurstW-1:0]                    count_i,
  output logic                                 load_ok_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ssr_pkg::BYTE_W-1:0]           out_byte_o,
  output logic                                 out_bvalid_o,
  output logic                                 out_last_o
);

  logic [DEPTH-1:0][ssr_pkg::BYTE_W-1:0] bytes_q;
  logic [BurstW-1:0]                     cnt_q;
  logic                                  marker_q;
  logic                                  pop;

  assign pop          = out_valid_o && out_ready_i;
  assign out_valid_o  = cnt_q != '0;
  assign out_last_o   = cnt_q == BurstW'(1);
  assign out_byte_o   = bytes_q[0];
  assign out_bvalid_o = !marker_q;
  assign load_ok_o    = (cnt_q == '0) || (out_last_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      marker_q <= 1'b0;
    end else if (load_i.load) begin
      cnt_q    <= count_i;
      marker_q <= load_i.marker;
    end else if (pop) begin
      cnt_q <= cnt_q - BurstW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      bytes_q <= bytes_i;
    end else if (pop) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        bytes_q[j] <= bytes_q[j+1];
      end
    end
  end

endmodule

// ===== src/stream_search_replace.sv =====
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] text byte, tlast end of text
// m_axis    out  m_axis_tvalid/tready       tdata[7:0] out byte, tuser byte valid,
//                                           tlast last result of the input byte
// cfg       in   cfg_we_i                   cfg_idx_i register, cfg_data_i value
//
// One byte per cycle while each byte yields at most one result and m_axis is ready;
// a byte that yields n results keeps the result shift buffer busy until all n are sent.
// A result passes through the input register, then the result buffer, before its
// transaction. One further byte waits in the input register during a burst.
// Reset clears the window count and configuration; window bytes are not cleared.
// Input stalls only while the result buffer is busy and cannot take the next burst.
module stream_search_replace #(
  parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_SUBST   = ssr_pkg::MAX_SUBST_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] text_byte
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
  output logic                           m_axis_tuser,  // [0] byte_valid
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int Burst  = (MAX_PATTERN > MAX_SUBST) ? MAX_PATTERN : MAX_SUBST;
  localparam int BurstW = $clog2(Burst + 1);

  ssr_pkg::cfg_t                         cfg;
  ssr_pkg::load_t                        load;
  logic [Burst-1:0][ssr_pkg::BYTE_W-1:0] bytes;
  logic [BurstW-1:0]                     count;
  logic                                  load_ok;

  ssr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ssr_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_SUBST   (MAX_SUBST),
    .BURST       (Burst)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eot_i   (s_axis_tlast),
    .cfg_i      (cfg),
    .load_ok_i  (load_ok),
    .load_o     (load),
    .bytes_o    (bytes),
    .count_o    (count)
  );

  ssr_burst #(
    .DEPTH (Burst)
  ) u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .bytes_i      (bytes),
    .count_i      (count),
    .load_ok_o    (load_ok),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_bvalid_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== src/ssr_checker.sv =====
module ssr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("bare end marker malformed");

  a_rise_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without an input transaction");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output idle");

endmodule

bind stream_search_replace ssr_checker u_ssr_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ssr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } rewrite_t;

  class rewrite_scoreboard;
    logic [CFG_DATA_W-1:0] pat_lo, pat_hi, sub_lo, sub_hi;
    logic [LEN_W-1:0]      pat_len, sub_len;
    logic [7:0]            window [16];
    int                    fill;
    int                    errors;
    rewrite_t              burst [$];
    rewrite_t              expected_q [$];

    function new();
      pat_lo = '0;
      pat_hi = '0;
      sub_lo = '0;
      sub_hi = '0;
      pat_len = '0;
      sub_len = '0;
      fill = 0;
      errors = 0;
    endfunction

    function logic [7:0] byte_of(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi, int k);
      if (k < 8) begin
        return lo[8*k +: 8];
      end else if (k < 16) begin
        return hi[8*(k-8) +: 8];
      end
      return 8'h00;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PAT_LO:  pat_lo = value;
        REG_PAT_HI:  pat_hi = value;
        REG_PAT_LEN: pat_len = value[LEN_W-1:0];
        REG_SUB_LO:  sub_lo = value;
        REG_SUB_HI:  sub_hi = value;
        REG_SUB_LEN: sub_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void shift_out();
      burst.push_back('{data: window[0], valid: 1'b1, last: 1'b0});
      for (int i = 0; i < fill - 1; i++) window[i] = window[i+1];
      fill--;
    endfunction

    function void note_text(logic [7:0] b, logic eot);
      int plen;
      int slen;
      bit hit;
      burst.delete();
      plen = (pat_len > 16) ? 16 : int'(pat_len);
      slen = (sub_len > 16) ? 16 : int'(sub_len);
      if (fill >= 16) shift_out();
      window[fill] = b;
      fill++;
      if (plen == 0) begin
        while (fill > 0) shift_out();
      end else if (fill > plen) begin
        while (fill >= plen) shift_out();
      end else if (fill == plen) begin
        hit = 1'b1;
        for (int k = 0; k < plen; k++) begin
          if (window[k] != byte_of(pat_lo, pat_hi, k)) hit = 1'b0;
        end
        if (hit) begin
          for (int k = 0; k < slen; k++) begin
            burst.push_back('{data: byte_of(sub_lo, sub_hi, k), valid: 1'b1, last: 1'b0});
          end
          fill = 0;
        end else begin
          shift_out();
        end
      end
      if (eot) begin
        while (fill > 0) shift_out();
        if (burst.size() == 0) burst.push_back('{data: 8'h00, valid: 1'b0, last: 1'b0});
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_q.push_back(burst[i]);
    endfunction

    function void check_result(logic [7:0] data, logic valid, logic last);
      rewrite_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte %02h byte_valid %0b last_of_run %0b",
               data, valid, last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        errors++;
      end
      if (valid !== want.valid) begin
        $error("byte_valid: expected %0b, got %0b", want.valid, valid);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;  // [7:0] text_byte
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;          // [7:0] out_byte
  logic                  m_axis_tuser;          // [0] byte_valid
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int send_idle = 0;
  int recv_idle = 0;

  rewrite_scoreboard sb = new();

  stream_search_replace uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // length in the low bits, sometimes with junk above it
  function automatic logic [63:0] len_word(int len);
    logic [63:0] w;
    w = rand64();
    w[LEN_W-1:0] = len[LEN_W-1:0];
    if ($urandom_range(1) == 0) w[63:LEN_W] = '0;
    return w;
  endfunction

  task automatic send_text(input logic [7:0] b, input logic eot);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_text(b, eot);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic load_config(input logic [63:0] pl, input logic [63:0] ph, input int plen,
                             input logic [63:0] sl, input logic [63:0] sh, input int slen);
    write_reg(REG_PAT_LO, pl);
    write_reg(REG_PAT_HI, ph);
    write_reg(REG_PAT_LEN, len_word(plen));
    write_reg(REG_SUB_LO, sl);
    write_reg(REG_SUB_HI, sh);
    write_reg(REG_SUB_LEN, len_word(slen));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly whole pattern copies, some cut-off prefixes, some noise
  task automatic run_text(input logic [63:0] pl, input logic [63:0] ph, input int plen,
                          input int n_items, input bit close);
    logic [7:0] chunk [$];
    int         sent;
    int         r;
    int         eff;
    bit         eot;
    sent = 0;
    eff = (plen > 16) ? 16 : plen;
    while (sent < n_items) begin
      chunk.delete();
      r = $urandom_range(99);
      if (eff > 0 && r < 60) begin
        for (int k = 0; k < eff; k++) chunk.push_back(sb.byte_of(pl, ph, k));
      end else if (eff > 1 && r < 80) begin
        for (int k = 0; k < $urandom_range(1, eff - 1); k++) begin
          chunk.push_back(sb.byte_of(pl, ph, k));
        end
      end else begin
        repeat ($urandom_range(1, 3)) chunk.push_back(8'($urandom_range(255)));
      end
      foreach (chunk[i]) begin
        if (sent < n_items) begin
          eot = (close && sent == n_items - 1) || ($urandom_range(29) == 0);
          send_text(chunk[i], eot);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [63:0] pl;
    logic [63:0] ph;
    logic [63:0] sl;
    logic [63:0] sh;
    int          plen_tab [12];
    int          slen_tab [12];
    plen_tab = '{2, 0, 1, 16, 3, 31, 5, 17, 1, 4, 16, 2};
    slen_tab = '{16, 3, 0, 1, 31, 2, 0, 16, 5, 1, 20, 0};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 17;
    recv_idle = 75;

    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'hA5, 1'b1);
    settle();

    pl = rand64();
    pl[15:0] = 16'h6261;
    ph = rand64();
    sl = rand64();
    sh = rand64();
    load_config(pl, ph, 2, sl, sh, 16);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h78, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b1);
    settle();

    load_config(pl, ph, 2, sl, sh, 0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b1);
    settle();

    pl = rand64();
    load_config(pl, ph, 4, sl, sh, 3);
    for (int k = 0; k < 3; k++) send_text(sb.byte_of(pl, ph, k), 1'b0);
    settle();
    load_config(pl, ph, 2, sl, sh, 3);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);

    for (int p = 0; p < 12; p++) begin
      settle();
      if (p < 4) begin
        send_idle = 17;
        recv_idle = 75;
      end else if (p < 8) begin
        send_idle = 75;
        recv_idle = 17;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pl = rand64();
      ph = rand64();
      sl = rand64();
      sh = rand64();
      load_config(pl, ph, plen_tab[p], sl, sh, slen_tab[p]);
      run_text(pl, ph, plen_tab[p], 34, p == 11);
    end

    settle();
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
